// ----- hdl/dchs_pkg.sv -----
`timescale 1ns / 1ps

package dchs_pkg;

	// Widths of the stream words and the fields they carry.
	localparam int DATA_W   = 32;
	localparam int CYL_W    = 16;
	localparam int HEAD_W   = 5;
	localparam int SPT_W    = 8;

	// The clamped sector count always fits in 28 bits.
	localparam int TOT_W    = 28;
	// Quotient of the clamped count by the smallest divisor (17).
	localparam int QW       = 24;
	// Track count after the geometry pick, at most 1048560.
	localparam int TRK_W    = 21;
	// Remainder after one reciprocal step, below twice the divisor.
	localparam int REM_W    = 9;
	// Reciprocals of the sectors-per-track divisors, scaled by 2^32.
	localparam int FRAC     = 32;
	localparam int RECIP_W  = 28;
	localparam int PROD_W   = TOT_W + RECIP_W;

	// Head division: tracks below 15*1024, reciprocals scaled by 2^24.
	localparam int HFRAC    = 24;
	localparam int HTRK_W   = 14;
	localparam int HREC_W   = 23;
	localparam int HPROD_W  = HTRK_W + HREC_W;
	localparam int HQ_W     = 10;
	localparam int HREM_W   = 5;

	// Number of constant-divisor lanes.
	localparam int NLANE    = 4;

	// Geometry limits of the disk rule.
	localparam logic [TOT_W-1:0] MAX_SECTORS   = TOT_W'(65535 * 16 * 255);
	localparam logic [TOT_W-1:0] LARGE_SECTORS = TOT_W'(65535 * 16 * 63);
	localparam int               HEAD_SHIFT    = 10;
	localparam logic [HEAD_W-1:0] HEADS_MIN    = HEAD_W'(4);
	localparam logic [HEAD_W-1:0] HEADS_MAX    = HEAD_W'(16);
	localparam int               HEADS_MAX_LOG = 4;
	localparam int               TRACK_ROUND   = 1023;

	// One lane for each sectors-per-track choice.
	typedef enum logic [1:0] {
		LANE_17,
		LANE_31,
		LANE_63,
		LANE_255
	} lane_t;

	// Sectors per track served by a lane.
	function automatic logic [SPT_W-1:0] lane_div(input lane_t lane);
		logic [SPT_W-1:0] d;
		unique case (lane)
			LANE_17:  d = SPT_W'(17);
			LANE_31:  d = SPT_W'(31);
			LANE_63:  d = SPT_W'(63);
			LANE_255: d = SPT_W'(255);
			default:  d = SPT_W'(255);
		endcase
		return d;
	endfunction

	// Floor of 2^32 over the lane's divisor.
	function automatic logic [RECIP_W-1:0] lane_recip(input lane_t lane);
		logic [RECIP_W-1:0] m;
		unique case (lane)
			LANE_17:  m = RECIP_W'((64'd1 << FRAC) / 64'd17);
			LANE_31:  m = RECIP_W'((64'd1 << FRAC) / 64'd31);
			LANE_63:  m = RECIP_W'((64'd1 << FRAC) / 64'd63);
			LANE_255: m = RECIP_W'((64'd1 << FRAC) / 64'd255);
			default:  m = RECIP_W'((64'd1 << FRAC) / 64'd255);
		endcase
		return m;
	endfunction

	// Floor of 2^24 over a head count; sixteen heads take the shift path.
	function automatic logic [HREC_W-1:0] head_recip(input logic [HEAD_W-1:0] h);
		logic [HREC_W-1:0] m;
		unique case (h)
			HEAD_W'(4):  m = HREC_W'((32'd1 << HFRAC) / 32'd4);
			HEAD_W'(5):  m = HREC_W'((32'd1 << HFRAC) / 32'd5);
			HEAD_W'(6):  m = HREC_W'((32'd1 << HFRAC) / 32'd6);
			HEAD_W'(7):  m = HREC_W'((32'd1 << HFRAC) / 32'd7);
			HEAD_W'(8):  m = HREC_W'((32'd1 << HFRAC) / 32'd8);
			HEAD_W'(9):  m = HREC_W'((32'd1 << HFRAC) / 32'd9);
			HEAD_W'(10): m = HREC_W'((32'd1 << HFRAC) / 32'd10);
			HEAD_W'(11): m = HREC_W'((32'd1 << HFRAC) / 32'd11);
			HEAD_W'(12): m = HREC_W'((32'd1 << HFRAC) / 32'd12);
			HEAD_W'(13): m = HREC_W'((32'd1 << HFRAC) / 32'd13);
			HEAD_W'(14): m = HREC_W'((32'd1 << HFRAC) / 32'd14);
			HEAD_W'(15): m = HREC_W'((32'd1 << HFRAC) / 32'd15);
			default:     m = '0;
		endcase
		return m;
	endfunction

	// Quotients of the clamped count by every lane divisor.
	typedef struct packed {
		logic                       big;
		logic [NLANE-1:0][QW-1:0]   quot;
	} quot_t;

	// Chosen geometry before the cylinder division.
	typedef struct packed {
		logic [TRK_W-1:0]  tracks;
		logic [HEAD_W-1:0] heads;
		logic [SPT_W-1:0]  spt;
	} pick_t;

	// Final geometry.
	typedef struct packed {
		logic [CYL_W-1:0]  cyl;
		logic [HEAD_W-1:0] heads;
		logic [SPT_W-1:0]  spt;
	} geo_t;

endpackage

// ----- hdl/dchs_cdiv.sv -----
`timescale 1ns / 1ps

module dchs_cdiv import dchs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [DATA_W-1:0] total,
	output logic              out_valid,
	input  logic              out_ready,
	output quot_t             out_quot
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [TOT_W-1:0] tot_s1, tot_s2;
	logic             large_s1, large_s2, large_s3;
	logic [NLANE-1:0][PROD_W-1:0] prod_s2;
	logic [NLANE-1:0][QW-1:0]     q0_s3;
	logic [NLANE-1:0][REM_W-1:0]  rem_s3;
	quot_t                        quot_s4;

	logic [TOT_W-1:0]             tot_clamp;
	logic [NLANE-1:0][PROD_W-1:0] prod_c;
	logic [NLANE-1:0][QW-1:0]     q0_c;
	logic [NLANE-1:0][REM_W-1:0]  rem_c;
	logic [NLANE-1:0][QW-1:0]     quot_c;
	logic [NLANE-1:0][TOT_W-1:0]  back_c;

	// A stage takes new data when it is empty or its contents move on.
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// Clamp the count to the largest geometry.
	assign tot_clamp = (total > DATA_W'(MAX_SECTORS)) ? MAX_SECTORS : total[TOT_W-1:0];

	// Reciprocal products, quotient estimates and their correction per lane.
	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			prod_c[l] = PROD_W'(tot_s1) * PROD_W'(lane_recip(lane_t'(l)));
			q0_c[l]   = prod_s2[l][PROD_W-1:FRAC];
			back_c[l] = TOT_W'(q0_c[l] * lane_div(lane_t'(l)));
			rem_c[l]  = REM_W'(tot_s2 - back_c[l]);
			quot_c[l] = q0_s3[l] + QW'(rem_s3[l] >= REM_W'(lane_div(lane_t'(l))));
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			tot_s1   <= tot_clamp;
			large_s1 <= tot_clamp >= LARGE_SECTORS;
		end
		if (rdy2 && v_s1) begin
			tot_s2   <= tot_s1;
			large_s2 <= large_s1;
			prod_s2  <= prod_c;
		end
		if (rdy3 && v_s2) begin
			large_s3 <= large_s2;
			q0_s3    <= q0_c;
			rem_s3   <= rem_c;
		end
		if (rdy4 && v_s3) begin
			quot_s4.big  <= large_s3;
			quot_s4.quot <= quot_c;
		end
	end

	assign out_valid = v_s4;
	assign out_quot  = quot_s4;

endmodule

// ----- hdl/dchs_select.sv -----
`timescale 1ns / 1ps

module dchs_select import dchs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  quot_t in_quot,
	output logic  out_valid,
	input  logic  out_ready,
	output pick_t out_pick
);

	localparam int HRAW_W = QW + 1 - HEAD_SHIFT;

	logic  v_s5;
	pick_t pick_s5;
	pick_t pick_c;

	logic [QW:0]              round_sum;
	logic [HRAW_W-1:0]        h17_raw;
	logic [HRAW_W-1:0]        h17;
	logic [QW:0]              h17_span;
	logic                     fb_31;
	logic                     fb_63;
	logic [QW-1:0]            q17, q31, q63, q255;

	assign in_ready = !v_s5 || out_ready;

	assign q17  = in_quot.quot[LANE_17];
	assign q31  = in_quot.quot[LANE_31];
	assign q63  = in_quot.quot[LANE_63];
	assign q255 = in_quot.quot[LANE_255];

	// Heads needed at 17 sectors per track, at least four.
	assign round_sum = {1'b0, q17} + (QW+1)'(TRACK_ROUND);
	assign h17_raw   = round_sum[QW:HEAD_SHIFT];
	assign h17       = (h17_raw < HRAW_W'(HEADS_MIN)) ? HRAW_W'(HEADS_MIN) : h17_raw;
	assign h17_span  = (QW+1)'({h17, {HEAD_SHIFT{1'b0}}});

	// Fall back when 17 sectors need too many heads or tracks.
	assign fb_31 = (h17 > HRAW_W'(HEADS_MAX)) || (h17_span <= {1'b0, q17});
	assign fb_63 = q31 >= QW'({HEADS_MAX, {HEAD_SHIFT{1'b0}}});

	// Pick the geometry in the order of the rule.
	always_comb begin
		priority if (in_quot.big) begin
			pick_c.spt    = lane_div(LANE_255);
			pick_c.heads  = HEADS_MAX;
			pick_c.tracks = TRK_W'(q255);
		end else if (!fb_31) begin
			pick_c.spt    = lane_div(LANE_17);
			pick_c.heads  = h17[HEAD_W-1:0];
			pick_c.tracks = TRK_W'(q17);
		end else if (!fb_63) begin
			pick_c.spt    = lane_div(LANE_31);
			pick_c.heads  = HEADS_MAX;
			pick_c.tracks = TRK_W'(q31);
		end else begin
			pick_c.spt    = lane_div(LANE_63);
			pick_c.heads  = HEADS_MAX;
			pick_c.tracks = TRK_W'(q63);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (in_ready) begin
			v_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pick_s5 <= pick_c;
		end
	end

	assign out_valid = v_s5;
	assign out_pick  = pick_s5;

endmodule

// ----- hdl/dchs_hdiv.sv -----
`timescale 1ns / 1ps

module dchs_hdiv import dchs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  pick_t in_pick,
	output logic  out_valid,
	input  logic  out_ready,
	output geo_t  out_geo
);

	logic v_s6, v_s7, v_s8;
	logic rdy6, rdy7, rdy8;

	logic [HPROD_W-1:0] prod_s6;
	logic [TRK_W-1:0]   tracks_s6;
	logic [HEAD_W-1:0]  heads_s6, heads_s7;
	logic [SPT_W-1:0]   spt_s6, spt_s7;
	logic               full_s6, full_s7;
	logic [HQ_W-1:0]    q0_s7;
	logic [HREM_W-1:0]  rem_s7;
	logic [CYL_W-1:0]   shcyl_s7;
	geo_t               geo_s8;

	logic [HPROD_W-1:0] prod_c;
	logic [HQ_W-1:0]    q0_c;
	logic [HTRK_W-1:0]  back_c;
	logic [HREM_W-1:0]  rem_c;
	logic [CYL_W-1:0]   cyl_c;

	assign rdy8     = !v_s8 || out_ready;
	assign rdy7     = !v_s7 || rdy8;
	assign rdy6     = !v_s6 || rdy7;
	assign in_ready = rdy6;

	// Reciprocal estimate of tracks over heads, then one correction step.
	assign prod_c = HPROD_W'(in_pick.tracks[HTRK_W-1:0]) * HPROD_W'(head_recip(in_pick.heads));
	assign q0_c   = HQ_W'(prod_s6 >> HFRAC);
	assign back_c = HTRK_W'(q0_c * heads_s6);
	assign rem_c  = HREM_W'(tracks_s6[HTRK_W-1:0] - back_c);

	// Sixteen heads divide by a shift; other counts use the corrected estimate.
	assign cyl_c = full_s7 ? shcyl_s7 : CYL_W'(q0_s7 + HQ_W'(rem_s7 >= heads_s7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (rdy6) v_s6 <= in_valid;
			if (rdy7) v_s7 <= v_s6;
			if (rdy8) v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6 && in_valid) begin
			prod_s6   <= prod_c;
			tracks_s6 <= in_pick.tracks;
			heads_s6  <= in_pick.heads;
			spt_s6    <= in_pick.spt;
			full_s6   <= in_pick.heads == HEADS_MAX;
		end
		if (rdy7 && v_s6) begin
			q0_s7    <= q0_c;
			rem_s7   <= rem_c;
			shcyl_s7 <= CYL_W'(tracks_s6 >> HEADS_MAX_LOG);
			heads_s7 <= heads_s6;
			spt_s7   <= spt_s6;
			full_s7  <= full_s6;
		end
		if (rdy8 && v_s7) begin
			geo_s8.cyl   <= cyl_c;
			geo_s8.heads <= heads_s7;
			geo_s8.spt   <= spt_s7;
		end
	end

	assign out_valid = v_s8;
	assign out_geo   = geo_s8;

endmodule

// ----- hdl/disk_chs_geometry.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Bits of tdata
// s_        in         [31:0] total_sectors
// m_        out        [15:0] cylinders, [20:16] heads, [28:21] sectors_per_track
//
// One item enters per cycle unless every stage is full and the output is stalled.
// The eight register stages are clamp, reciprocal multiply, quotient estimate,
// quotient correction, geometry pick, head reciprocal multiply, estimate, correction.
// Each stage holds only while it is full and the stage after it is stalled,
// so bubbles close up and input is taken while a result waits at the output.
// Reset clears the valid bits; data registers are not reset.

module disk_chs_geometry import dchs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // total_sectors
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata    // cylinders, heads, sectors_per_track, zero fill
);

	localparam int PAD_W = DATA_W - CYL_W - HEAD_W - SPT_W;

	logic  quot_valid, quot_ready;
	quot_t quot;
	logic  pick_valid, pick_ready;
	pick_t pick;
	geo_t  geo;

	// Division of the clamped count by every sectors-per-track choice.
	dchs_cdiv u_cdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.total     (s_tdata),
		.out_valid (quot_valid),
		.out_ready (quot_ready),
		.out_quot  (quot)
	);

	// Choice of sectors per track and heads.
	dchs_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (quot_valid),
		.in_ready  (quot_ready),
		.in_quot   (quot),
		.out_valid (pick_valid),
		.out_ready (pick_ready),
		.out_pick  (pick)
	);

	// Cylinders from tracks over heads.
	dchs_hdiv u_hdiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pick_valid),
		.in_ready  (pick_ready),
		.in_pick   (pick),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_geo   (geo)
	);

	assign m_tdata = {{PAD_W{1'b0}}, geo.spt, geo.heads, geo.cyl};

endmodule

// ----- hdl/dchs_check.sv -----
`timescale 1ns / 1ps

module dchs_check import dchs_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	logic [HEAD_W-1:0] heads;
	logic [SPT_W-1:0]  spt;

	assign heads = m_tdata[CYL_W +: HEAD_W];
	assign spt   = m_tdata[CYL_W + HEAD_W +: SPT_W];

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// Heads stay within four to sixteen.
	a_heads: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (heads >= HEADS_MIN) && (heads <= HEADS_MAX))
		else $error("head count out of range");

	// Only the four sectors-per-track choices appear.
	a_spt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (spt == lane_div(LANE_17)) || (spt == lane_div(LANE_31)) ||
			(spt == lane_div(LANE_63)) || (spt == lane_div(LANE_255)))
		else $error("illegal sectors per track");

	// Every choice other than 17 sectors uses sixteen heads.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (spt != lane_div(LANE_17)) |-> heads == HEADS_MAX)
		else $error("fallback geometry without sixteen heads");

	// The padding above the fields stays zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[DATA_W-1:CYL_W + HEAD_W + SPT_W] == '0)
		else $error("nonzero padding in result");

endmodule

bind disk_chs_geometry dchs_check u_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ----- sim/geometry_checker.sv -----
`timescale 1ns / 1ps

module geometry_checker import dchs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // total_sectors
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,   // cylinders, heads, sectors_per_track, zero fill
	output int                errors,
	output int                pending
);

	// Layout of one result word, highest field first.
	typedef struct packed {
		logic [DATA_W-CYL_W-HEAD_W-SPT_W-1:0] pad;
		logic [SPT_W-1:0]                     spt;
		logic [HEAD_W-1:0]                    heads;
		logic [CYL_W-1:0]                     cyl;
	} chs_word_t;

	localparam int unsigned CLAMP_COUNT = 65535 * 16 * 255;
	localparam int unsigned BIG_COUNT   = 65535 * 16 * 63;
	localparam int unsigned TRACKS_PER_HEAD = 1024;

	chs_word_t geo_queue[$];
	int        fail_cnt = 0;
	int        depth    = 0;

	assign errors  = fail_cnt;
	assign pending = depth;

	// Geometry of the virtual-disk rule for one sector count.
	function automatic chs_word_t chs_from_count(input logic [DATA_W-1:0] count);
		int unsigned total;
		int unsigned spt;
		int unsigned hd;
		int unsigned trk;
		chs_word_t   g;
		total = count;
		if (total > CLAMP_COUNT)
			total = CLAMP_COUNT;
		if (total >= BIG_COUNT) begin
			spt = 255;
			hd  = 16;
			trk = total / spt;
		end else begin
			spt = 17;
			trk = total / spt;
			hd  = (trk + TRACKS_PER_HEAD - 1) / TRACKS_PER_HEAD;
			if (hd < 4)
				hd = 4;
			// Too many heads or too many tracks at 17 sectors: retry at 31.
			if (hd > 16 || trk >= hd * TRACKS_PER_HEAD) begin
				spt = 31;
				hd  = 16;
				trk = total / spt;
			end
			// Still too many tracks: settle on 63.
			if (trk >= hd * TRACKS_PER_HEAD) begin
				spt = 63;
				hd  = 16;
				trk = total / spt;
			end
		end
		g.pad   = '0;
		g.cyl   = CYL_W'(trk / hd);
		g.heads = HEAD_W'(hd);
		g.spt   = SPT_W'(spt);
		return g;
	endfunction

	// Match each output transfer against the oldest prediction, then log new input.
	always @(posedge clk) begin
		chs_word_t want;
		chs_word_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = chs_word_t'(m_tdata);
				if (geo_queue.size() == 0) begin
					$error("unexpected result transfer: tdata %h", m_tdata);
					fail_cnt = fail_cnt + 1;
				end else begin
					want = geo_queue.pop_front();
					if (got.cyl !== want.cyl) begin
						$error("cylinders: expected %0d, got %0d", want.cyl, got.cyl);
						fail_cnt = fail_cnt + 1;
					end
					if (got.heads !== want.heads) begin
						$error("heads: expected %0d, got %0d", want.heads, got.heads);
						fail_cnt = fail_cnt + 1;
					end
					if (got.spt !== want.spt) begin
						$error("sectors_per_track: expected %0d, got %0d", want.spt, got.spt);
						fail_cnt = fail_cnt + 1;
					end
					if (got.pad !== want.pad) begin
						$error("zero fill: expected %0d, got %0d", want.pad, got.pad);
						fail_cnt = fail_cnt + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				geo_queue.push_back(chs_from_count(s_tdata));
			depth = geo_queue.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import dchs_pkg::*;

	localparam int RANDOM_ITEMS = 1950;
	localparam int DRAIN_CYCLES = 16;

	localparam logic [DATA_W-1:0] CLAMP_COUNT = 65535 * 16 * 255;
	localparam logic [DATA_W-1:0] BIG_COUNT   = 65535 * 16 * 63;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata  = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	int                errors;
	int                pending;

	always #5 clk = ~clk;

	disk_chs_geometry dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	geometry_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// Offer one count and hold it until the transfer happens.
	task automatic send_count(input logic [DATA_W-1:0] count);
		s_tdata  = count;
		s_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Drop valid for a random gap, or keep streaming.
	task automatic sender_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Random counts, weighted toward the small-disk fallbacks and their edges.
	function automatic logic [DATA_W-1:0] pick_count();
		logic [DATA_W-1:0] v;
		int unsigned       spt;
		int                delta;
		case ($urandom_range(0, 99)) inside
			[0:24]:  v = $urandom();
			[25:59]: v = $urandom_range(0, BIG_COUNT);
			[60:74]: v = $urandom_range(0, 600000);
			[75:89]: begin
				case ($urandom_range(0, 2))
					0:       spt = 17;
					1:       spt = 31;
					default: spt = 63;
				endcase
				delta = $urandom_range(0, 80);
				v = spt * 1024 * $urandom_range(1, 16) + delta - 40;
			end
			[90:94]: v = BIG_COUNT + $urandom_range(0, 200) - 100;
			default: v = CLAMP_COUNT + $urandom_range(0, 200) - 100;
		endcase
		return v;
	endfunction

	// Receiver readiness follows changing patterns, including full-rate stretches.
	initial begin
		int mode;
		int span;
		int k;
		forever begin
			mode = $urandom_range(0, 4);
			span = $urandom_range(20, 200);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0:       m_tready = 1'b1;
					1:       m_tready = 1'($urandom_range(0, 1));
					2:       m_tready = ($urandom_range(0, 3) != 0);
					3:       m_tready = ((k % 4) == 0);
					default: m_tready = ((k % 16) >= 12);
				endcase
			end
		end
	end

	// Hard stop if the pipeline hangs.
	initial begin
		#5_000_000;
		$display("[disk_chs_geometry] ERROR");
		$finish;
	end

	initial begin
		logic [DATA_W-1:0] directed[$];
		int                i;
		int                sent;
		int                burst;

		// Zero and tiny counts, where the head count stays at four.
		directed.push_back(32'd0);
		directed.push_back(32'd1);
		directed.push_back(32'd16);
		directed.push_back(32'd17);
		// Four heads at 17 sectors: last fit, then exactly heads*1024 tracks.
		directed.push_back(32'd69631);
		directed.push_back(32'd69632);
		directed.push_back(32'd69649);
		// Sixteen heads at 17 sectors: last fit, then head overflow.
		directed.push_back(32'd278511);
		directed.push_back(32'd278528);
		directed.push_back(32'd278545);
		// Track overflow at 31 sectors into 63.
		directed.push_back(32'd507903);
		directed.push_back(32'd507904);
		// Large-disk threshold.
		directed.push_back(BIG_COUNT - 1);
		directed.push_back(BIG_COUNT);
		directed.push_back(BIG_COUNT + 1);
		// Clamp threshold and oversized counts.
		directed.push_back(CLAMP_COUNT - 1);
		directed.push_back(CLAMP_COUNT);
		directed.push_back(CLAMP_COUNT + 1);
		directed.push_back(32'h8000_0000);
		directed.push_back(32'hFFFF_FFFF);

		// Hold reset at the start, then release it.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_count(directed[i]);
		sender_gap();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 24);
			for (i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
				send_count(pick_count());
				sent++;
			end
			sender_gap();
		end
		s_tvalid = 1'b0;

		// Drain, then watch a little longer for stray results.
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("[disk_chs_geometry] OK");
		else
			$display("[disk_chs_geometry] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/dchs_pkg.sv
hdl/dchs_cdiv.sv
hdl/dchs_select.sv
hdl/dchs_hdiv.sv
hdl/disk_chs_geometry.sv
hdl/dchs_check.sv
sim/geometry_checker.sv
sim/tb.sv
